// File: rtl/core/lss_pkg.sv
// Shared types and constants for the LIFO stack with membership search.
package lss_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;
   localparam int ACTION_W      = 2;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_SEARCH = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       push_write;
      logic       pop_issue;
      logic       pop_commit;
      logic       scan_start;
      logic       scan_step;
      logic       status_wr;
      status_type status_code;
      logic       emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type action;
      logic       full;
      logic       empty;
      logic       scan_done;
      logic       out_free;
   } dp_stat_type;

endpackage

// File: rtl/core/lss_channels.sv
// Valid/ready channel interfaces for the request and response transactions.
interface lss_req_if;
   logic                                valid;
   logic                                ready;
   logic [lss_pkg::ACTION_W-1:0]        action;
   logic signed [lss_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface lss_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [lss_pkg::STATUS_W-1:0]         status;
   logic                                 found;
   logic                                 is_empty;
   logic [lss_pkg::COUNT_OUT_W-1:0]      entry_count;
   logic signed [lss_pkg::VALUE_W-1:0]   total;

   modport source (output valid, output status, output found, output is_empty,
                   output entry_count, output total, input ready);
   modport sink   (input valid, input status, input found, input is_empty,
                   input entry_count, input total, output ready);
endinterface

// File: rtl/core/lss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/lss_datapath.sv
// Datapath: latched request, stack pointer, running sum, search scan and response register.
module lss_datapath #(
   parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lss_pkg::ctrl_cmd_type               cmd,
   output lss_pkg::dp_stat_type                stat,
   input  logic [lss_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [lss_pkg::VALUE_W-1:0]  req_value,
   lss_rsp_if.source                           rsp
);
   import lss_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   action_type          action_ff;
   logic [VALUE_W-1:0]  value_ff;
   status_type          status_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [VALUE_W-1:0]  total_ff, total_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic                rsp_found_ff;
   logic                rsp_empty_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic [VALUE_W-1:0]  rsp_total_ff;

   logic [CW-1:0]       count_dec;
   logic [AW-1:0]       rd_addr;
   logic [VALUE_W-1:0]  rd_data;
   logic                scan_issue;
   logic                match;
   logic [CW+COUNT_OUT_W-1:0] count_ext;

   assign count_dec  = count_ff - CW'(1);
   assign scan_issue = cmd.scan_step && (idx_ff < count_ff);
   assign rd_addr    = cmd.pop_issue ? count_dec[AW-1:0] : idx_ff[AW-1:0];
   assign match      = cmp_valid_ff && (rd_data == value_ff);
   assign count_ext  = {{COUNT_OUT_W{1'b0}}, count_ff};

   lss_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push_write),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      if (cmd.push_write) begin
         count_in = count_ff + CW'(1);
         total_in = total_ff + value_ff;
      end else if (cmd.pop_commit) begin
         count_in = count_dec;
         total_in = total_ff - rd_data;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      cmp_valid_in = scan_issue;
      found_in     = found_ff | match;
      if (cmd.scan_start) begin
         idx_in       = '0;
         cmp_valid_in = 1'b0;
         found_in     = 1'b0;
      end else if (scan_issue) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.load) begin
         found_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      found_ff <= found_in;
      if (cmd.load) begin
         action_ff <= action_type'(req_action);
         value_ff  <= req_value;
         status_ff <= STATUS_DONE;
      end else if (cmd.status_wr) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_empty_ff  <= (count_ff == '0);
         rsp_count_ff  <= count_ext[COUNT_OUT_W-1:0];
         rsp_total_ff  <= total_ff;
      end
   end

   assign stat.action    = action_ff;
   assign stat.full      = (count_ff == CW'(DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.scan_done = match || found_ff || ((idx_ff == count_ff) && !cmp_valid_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.found       = rsp_found_ff;
   assign rsp.is_empty    = rsp_empty_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign rsp.total       = rsp_total_ff;
endmodule

// File: rtl/core/lss_controller.sv
// Controller: sequences push, pop and search transactions over the datapath.
module lss_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lss_pkg::dp_stat_type   stat,
   output lss_pkg::ctrl_cmd_type  cmd
);
   import lss_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.status_code = STATUS_DONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (stat.action)
               ACT_PUSH: begin
                  if (stat.full) begin
                     cmd.status_wr   = 1'b1;
                     cmd.status_code = STATUS_FULL;
                  end else begin
                     cmd.push_write = 1'b1;
                  end
               end
               ACT_POP: begin
                  if (stat.empty) begin
                     cmd.status_wr   = 1'b1;
                     cmd.status_code = STATUS_EMPTY;
                  end else begin
                     cmd.pop_issue = 1'b1;
                     state_in      = ST_POP_WAIT;
                  end
               end
               ACT_SEARCH: begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_POP_WAIT: begin
            cmd.pop_commit = 1'b1;
            state_in       = ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// File: rtl/core/lifo_stack_with_search_top.sv
// Top level of the LIFO stack with membership search.
// A last-in-first-out store of up to DEPTH signed 32-bit values held in one
// RAM with registered read. Each request transaction carries an action: push
// (0) places value on top, pop (1) drops the top entry, search (2) reports
// whether value is stored; code 3 does nothing. Every request yields exactly
// one response transaction with a status (done, pop on empty ignored, push on
// full ignored), the found flag, the empty flag, the entry count (low five
// bits) and the wrapping sum of all entries after the action. A pop issues one
// RAM read to fetch the top entry before the sum is corrected, and a search
// reads one entry per cycle through the single RAM read port and stops at the
// first hit. One request is in flight at a time; a finished response sits in
// its output register, so the next request is accepted while the previous
// response still waits for its ready.
module lifo_stack_with_search_top #(
   parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lss_req_if.sink   req_bus,
   lss_rsp_if.source rsp_bus
);
   import lss_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         ctrl_ready;

   // Hand the request handshake to the controller, the payload to the datapath.
   assign req_bus.ready = ctrl_ready;

   lss_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctrl_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lss_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (req_bus.action),
      .req_value  (req_bus.value),
      .rsp        (rsp_bus)
   );
endmodule
